// ----- rtl/aqa_pkg.sv -----
// ----------------------------------------------------------------------------
// aqa_pkg
// Shared types and constants of the shadow atlas block allocator.
// ----------------------------------------------------------------------------
package aqa_pkg;

   localparam int ID_W   = 64;
   localparam int HASH_W = 64;
   localparam int SIZE_W = 4;
   localparam int CRD_W  = 14;   // texel coordinate, covers the largest atlas
   localparam int LVL_W  = 4;    // quadtree level, covers the deepest tree

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_NO_BLOCK   = 2'd1;
   localparam status_type STATUS_TABLE_FULL = 2'd2;

   localparam logic [0:0] REG_STATIC_CACHE = 1'b0;

   // classified request as it travels from the front to the back
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [HASH_W-1:0] hash;
      logic [SIZE_W-1:0] lg;
      logic [LVL_W-1:0]  lvl;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [HASH_W-1:0] hash;
      logic [CRD_W-1:0]  x;
      logic [CRD_W-1:0]  y;
      logic [LVL_W-1:0]  lvl;
   } entry_type;

   typedef struct packed {
      logic done;
      logic found;
      logic free_ok;
   } look_rsp_type;

   typedef struct packed {
      logic             do_free;
      logic [LVL_W-1:0] free_lvl;
      logic [CRD_W-1:0] free_x;
      logic [CRD_W-1:0] free_y;
      logic [LVL_W-1:0] alloc_lvl;
   } alloc_cmd_type;

   typedef struct packed {
      logic             ready;
      logic             done;
      logic             ok;
      logic [CRD_W-1:0] x;
      logic [CRD_W-1:0] y;
   } alloc_rsp_type;

   typedef enum logic [1:0] {
      L_IDLE,
      L_SCAN,
      L_DRAIN
   } look_state_type;

   typedef enum logic [4:0] {
      A_INIT,
      A_IDLE,
      A_FREE_CHK,
      A_PUSH,
      A_SCAN_RD,
      A_SCAN_USE,
      A_SCAN_END,
      A_DEL_RD,
      A_DEL_WR,
      A_MERGE,
      A_INS_RD,
      A_INS_WR,
      A_INS_PUT,
      A_ALLOC_CHK,
      A_SPLIT_RD,
      A_SPLIT_USE,
      A_SPLIT_PUSH,
      A_POP_RD,
      A_POP_USE,
      A_DONE
   } alloc_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_LOOK,
      B_WAIT,
      B_DECIDE,
      B_AWAIT,
      B_OUT
   } back_state_type;

endpackage

// ----- rtl/atlas_quadtree_allocator.sv -----
// Lookup: a known light is found by scanning the light table one entry a cycle;
//   with no match the whole table is scanned. An allocation splits one level at a
//   time, and a free scans and moves its free-list entries one by one.
// Throughput: one item at a time; the two-entry queue takes items meanwhile.
// Reset: synchronous; clears the light table, then fills the top-level free
//   list, one block a cycle (16 blocks by default), before items are served.
// ----------------------------------------------------------------------------
// atlas_quadtree_allocator
// Shadow atlas block allocator with a request queue, light table and
// quadtree buddy free lists.
// ----------------------------------------------------------------------------
module atlas_quadtree_allocator #(
   parameter int ATLAS_WIDTH    = 8192,
   parameter int ATLAS_HEIGHT   = 8192,
   parameter int MAX_BLOCK_LOG2 = 11,
   parameter int MIN_BLOCK_LOG2 = 7,
   parameter int MAX_LIGHTS     = 64,
   parameter int LIST_DEPTH     = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [aqa_pkg::ID_W-1:0]    req_light_id,
   input  logic [aqa_pkg::HASH_W-1:0]  req_movement_hash,
   input  logic [aqa_pkg::SIZE_W-1:0]  req_size_log2,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [12:0]                 rsp_block_x,
   output logic [12:0]                 rsp_block_y,
   output logic [11:0]                 rsp_block_size,
   output logic                        rsp_static_hit,
   output logic [1:0]                  rsp_status,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import aqa_pkg::*;

   localparam int NUM_LEVELS = MAX_BLOCK_LOG2 - MIN_BLOCK_LOG2 + 1;

   logic    cache_en_ff, cache_en_in;
   logic    q_valid, q_pop;
   req_type q_item;
   logic    reg_sel;

   assign reg_sel = (paddr[2] == REG_STATIC_CACHE);
   assign pready  = 1'b1;
   assign prdata  = reg_sel ? {31'd0, cache_en_ff} : 32'd0;

   always_comb begin
      cache_en_in = cache_en_ff;
      if (psel && penable && pwrite && reg_sel) cache_en_in = pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_en_ff <= 1'b1;
      end else begin
         cache_en_ff <= cache_en_in;
      end
   end

   aqa_front #(
      .MAX_BLOCK_LOG2(MAX_BLOCK_LOG2),
      .MIN_BLOCK_LOG2(MIN_BLOCK_LOG2)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_light_id     (req_light_id),
      .req_movement_hash(req_movement_hash),
      .req_size_log2    (req_size_log2),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_item           (q_item)
   );

   aqa_back #(
      .ATLAS_WIDTH   (ATLAS_WIDTH),
      .ATLAS_HEIGHT  (ATLAS_HEIGHT),
      .MAX_BLOCK_LOG2(MAX_BLOCK_LOG2),
      .NUM_LEVELS    (NUM_LEVELS),
      .MAX_LIGHTS    (MAX_LIGHTS),
      .LIST_DEPTH    (LIST_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cache_en      (cache_en_ff),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_item        (q_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_block_x   (rsp_block_x),
      .rsp_block_y   (rsp_block_y),
      .rsp_block_size(rsp_block_size),
      .rsp_static_hit(rsp_static_hit),
      .rsp_status    (rsp_status)
   );

endmodule

// ----- rtl/aqa_front.sv -----
// ----------------------------------------------------------------------------
// aqa_front
// Accepts request items, clamps the size to the tree and queues them.
// ----------------------------------------------------------------------------
module aqa_front #(
   parameter int MAX_BLOCK_LOG2 = 11,
   parameter int MIN_BLOCK_LOG2 = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [aqa_pkg::ID_W-1:0]    req_light_id,
   input  logic [aqa_pkg::HASH_W-1:0]  req_movement_hash,
   input  logic [aqa_pkg::SIZE_W-1:0]  req_size_log2,
   output logic                        q_valid,
   input  logic                        q_pop,
   output aqa_pkg::req_type            q_item
);
   import aqa_pkg::*;

   localparam logic [SIZE_W-1:0] LG_MIN = SIZE_W'(MIN_BLOCK_LOG2);
   localparam logic [SIZE_W-1:0] LG_MAX = SIZE_W'(MAX_BLOCK_LOG2);

   req_type     ent_ff [2];
   req_type     item_in;
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;
   logic [SIZE_W-1:0] lg;

   always_comb begin
      if (req_size_log2 < LG_MIN) begin
         lg = LG_MIN;
      end else if (req_size_log2 > LG_MAX) begin
         lg = LG_MAX;
      end else begin
         lg = req_size_log2;
      end
      item_in.id   = req_light_id;
      item_in.hash = req_movement_hash;
      item_in.lg   = lg;
      item_in.lvl  = LVL_W'(LG_MAX - lg);
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = ent_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= item_in;
      end
   end

endmodule

// ----- rtl/aqa_lights.sv -----
// ----------------------------------------------------------------------------
// aqa_lights
// Light table: valid bits in flops, entries in a memory scanned one a cycle.
// ----------------------------------------------------------------------------
module aqa_lights #(
   parameter int  MAX_LIGHTS = 64,
   localparam int SW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      look_start,
   input  logic [aqa_pkg::ID_W-1:0]  look_id,
   output aqa_pkg::look_rsp_type     look_rsp,
   output logic [SW-1:0]             hit_slot,
   output logic [SW-1:0]             free_slot,
   output aqa_pkg::entry_type        hit_entry,
   input  logic                      wr_en,
   input  logic [SW-1:0]             wr_slot,
   input  aqa_pkg::entry_type        wr_entry,
   input  logic                      clr_en,
   input  logic [SW-1:0]             clr_slot
);
   import aqa_pkg::*;

   localparam logic [SW-1:0] LAST = SW'(MAX_LIGHTS - 1);

   entry_type       lights_mem [MAX_LIGHTS];
   entry_type       rd_ff;
   logic            rd_en;

   look_state_type  state_ff, state_in;
   logic [MAX_LIGHTS-1:0] valid_ff, valid_in;
   logic [SW-1:0]   idx_ff, idx_in;
   logic            chk_v_ff, chk_v_in;
   logic [SW-1:0]   chk_ff, chk_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic            found_ff, found_in, free_ok_ff, free_ok_in, done_ff, done_in;
   logic [SW-1:0]   slot_ff, slot_in, fslot_ff, fslot_in;
   entry_type       ent_ff, ent_in;
   logic            busy, match, vacant, finish;

   assign busy   = (state_ff != L_IDLE);
   assign match  = busy && chk_v_ff && valid_ff[chk_ff] && (rd_ff.id == id_ff);
   assign vacant = busy && chk_v_ff && !valid_ff[chk_ff];
   assign finish = match || (state_ff == L_DRAIN && chk_v_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         L_IDLE: begin
            if (look_start) state_in = L_SCAN;
         end
         L_SCAN: begin
            if (finish) begin
               state_in = L_IDLE;
            end else if (idx_ff == LAST) begin
               state_in = L_DRAIN;
            end
         end
         L_DRAIN: state_in = L_IDLE;
         default: state_in = L_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rd_en    = (state_ff == L_SCAN);
      chk_v_in = (state_ff == L_SCAN);
      done_in  = busy && finish;
   end

   always_comb begin
      idx_in     = idx_ff;
      chk_in     = idx_ff;
      id_in      = id_ff;
      found_in   = found_ff;
      free_ok_in = free_ok_ff;
      slot_in    = slot_ff;
      fslot_in   = fslot_ff;
      ent_in     = ent_ff;
      valid_in   = valid_ff;
      if (state_ff == L_IDLE && look_start) begin
         id_in      = look_id;
         idx_in     = '0;
         found_in   = 1'b0;
         free_ok_in = 1'b0;
      end
      if (state_ff == L_SCAN && idx_ff != LAST) begin
         idx_in = idx_ff + SW'(1);
      end
      if (match) begin
         found_in = 1'b1;
         slot_in  = chk_ff;
         ent_in   = rd_ff;
      end
      if (vacant && !free_ok_ff) begin
         free_ok_in = 1'b1;
         fslot_in   = chk_ff;
      end
      if (wr_en)  valid_in[wr_slot]  = 1'b1;
      if (clr_en) valid_in[clr_slot] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= L_IDLE;
         valid_ff   <= '0;
         chk_v_ff   <= 1'b0;
         found_ff   <= 1'b0;
         free_ok_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         chk_v_ff   <= chk_v_in;
         found_ff   <= found_in;
         free_ok_ff <= free_ok_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      chk_ff   <= chk_in;
      id_ff    <= id_in;
      slot_ff  <= slot_in;
      fslot_ff <= fslot_in;
      ent_ff   <= ent_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= lights_mem[idx_ff];
      if (wr_en) lights_mem[wr_slot] <= wr_entry;
   end

   assign look_rsp.done    = done_ff;
   assign look_rsp.found   = found_ff;
   assign look_rsp.free_ok = free_ok_ff;
   assign hit_slot  = slot_ff;
   assign free_slot = fslot_ff;
   assign hit_entry = ent_ff;

endmodule

// ----- rtl/aqa_alloc.sv -----
// ----------------------------------------------------------------------------
// aqa_alloc
// Quadtree buddy engine: per-level ordered free lists in one memory; frees
// with buddy merge, then allocates with splitting.
// ----------------------------------------------------------------------------
module aqa_alloc #(
   parameter int ATLAS_WIDTH    = 8192,
   parameter int ATLAS_HEIGHT   = 8192,
   parameter int MAX_BLOCK_LOG2 = 11,
   parameter int NUM_LEVELS     = 5,
   parameter int LIST_DEPTH     = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  aqa_pkg::alloc_cmd_type cmd,
   output aqa_pkg::alloc_rsp_type rsp
);
   import aqa_pkg::*;

   localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int LV_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int NX     = ATLAS_WIDTH >> MAX_BLOCK_LOG2;
   localparam int NY     = ATLAS_HEIGHT >> MAX_BLOCK_LOG2;
   localparam int INIT_N = (NX * NY < LIST_DEPTH) ? NX * NY : LIST_DEPTH;
   localparam logic [CNT_W-1:0] FULL     = CNT_W'(LIST_DEPTH);
   localparam logic [CNT_W-1:0] INIT_CNT = CNT_W'(INIT_N);
   localparam logic [CRD_W-1:0] BLK      = CRD_W'(1 << MAX_BLOCK_LOG2);
   localparam logic [CRD_W-1:0] X_LAST   = CRD_W'(((NX > 0) ? NX - 1 : 0) << MAX_BLOCK_LOG2);

   logic [2*CRD_W-1:0] free_mem [NUM_LEVELS][LIST_DEPTH];
   logic [2*CRD_W-1:0] rd_ff, wr_data;
   logic               rd_en, wr_en;
   logic [LV_W-1:0]    rd_lv, wr_lv;
   logic [IDX_W-1:0]   rd_idx, wr_idx;

   alloc_state_type    state_ff, state_in;
   logic [CNT_W-1:0]   counts_ff [NUM_LEVELS];
   logic [CNT_W-1:0]   counts_in [NUM_LEVELS];
   logic [LV_W-1:0]    lv_ff, lv_in, alv_ff, alv_in;
   logic [CRD_W-1:0]   x_ff, x_in, y_ff, y_in, ix_ff, ix_in, iy_ff, iy_in;
   logic [CRD_W-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic [CNT_W-1:0]   k_ff, k_in, eq_ff, eq_in, ins_ff, ins_in, j_ff, j_in;
   logic [1:0]         q_ff, q_in;
   logic               ok_ff, ok_in;

   logic [LV_W-1:0]    lv_up;
   logic [CNT_W-1:0]   n, m;
   logic [4:0]         psh, hsh;
   logic [CRD_W-1:0]   mask, half, ex, ey, cx, cy;
   logic               key_eq, key_gt, last_k, merge, init_done, src_ok;
   logic [LV_W-1:0]    src_lv;

   assign lv_up     = lv_ff + LV_W'(1);
   assign n         = counts_ff[lv_ff];
   assign m         = counts_ff[lv_up];
   assign init_done = (counts_ff[0] == INIT_CNT);
   assign psh       = 5'(MAX_BLOCK_LOG2 + 1) - 5'(lv_ff);
   assign hsh       = 5'(MAX_BLOCK_LOG2 - 1) - 5'(lv_ff);
   assign mask      = ~((CRD_W'(1) << psh) - CRD_W'(1));
   assign half      = CRD_W'(1) << hsh;
   assign ex        = rd_ff[2*CRD_W-1:CRD_W] & mask;
   assign ey        = rd_ff[CRD_W-1:0] & mask;
   // parent order is row-major, so compare the masked y first, then x
   assign key_eq    = (ey == (y_ff & mask)) && (ex == (x_ff & mask));
   assign key_gt    = (ey > (y_ff & mask)) || ((ey == (y_ff & mask)) && (ex > (x_ff & mask)));
   assign last_k    = (k_ff + CNT_W'(1) == n);
   assign merge     = (eq_ff == CNT_W'(3)) && (ins_ff >= CNT_W'(3));

   // nearest non-empty level at or above the target size
   always_comb begin
      src_ok = 1'b0;
      src_lv = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (LV_W'(i) <= alv_ff && counts_ff[i] != '0) begin
            src_ok = 1'b1;
            src_lv = LV_W'(i);
         end
      end
   end

   always_comb begin
      case (q_ff)
         2'd0: begin cx = x_ff;        cy = y_ff;        end
         2'd1: begin cx = x_ff + half; cy = y_ff;        end
         2'd2: begin cx = x_ff;        cy = y_ff + half; end
         default: begin cx = x_ff + half; cy = y_ff + half; end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         A_INIT:      if (init_done) state_in = A_IDLE;
         A_IDLE:      if (start) state_in = cmd.do_free ? A_FREE_CHK : A_ALLOC_CHK;
         A_FREE_CHK:  state_in = (lv_ff == '0 || n == '0) ? A_PUSH : A_SCAN_RD;
         A_PUSH:      state_in = A_ALLOC_CHK;
         A_SCAN_RD:   state_in = A_SCAN_USE;
         A_SCAN_USE:  state_in = (key_gt || last_k) ? A_SCAN_END : A_SCAN_RD;
         A_SCAN_END: begin
            if (merge) begin
               state_in = (ins_ff == n) ? A_MERGE : A_DEL_RD;
            end else if (n < FULL) begin
               state_in = (ins_ff == n) ? A_INS_PUT : A_INS_RD;
            end else begin
               state_in = A_ALLOC_CHK;
            end
         end
         A_DEL_RD:    state_in = A_DEL_WR;
         A_DEL_WR:    state_in = (j_ff + CNT_W'(1) == n) ? A_MERGE : A_DEL_RD;
         A_MERGE:     state_in = A_FREE_CHK;
         A_INS_RD:    state_in = A_INS_WR;
         A_INS_WR:    state_in = (j_ff - CNT_W'(1) == ins_ff) ? A_INS_PUT : A_INS_RD;
         A_INS_PUT:   state_in = A_ALLOC_CHK;
         A_ALLOC_CHK: begin
            if (!src_ok) begin
               state_in = A_DONE;
            end else begin
               state_in = (src_lv == alv_ff) ? A_POP_RD : A_SPLIT_RD;
            end
         end
         A_SPLIT_RD:  state_in = A_SPLIT_USE;
         A_SPLIT_USE: state_in = A_SPLIT_PUSH;
         A_SPLIT_PUSH: begin
            if (q_ff == 2'd3) state_in = (lv_up == alv_ff) ? A_POP_RD : A_SPLIT_RD;
         end
         A_POP_RD:    state_in = A_POP_USE;
         A_POP_USE:   state_in = A_DONE;
         A_DONE:      state_in = A_IDLE;
         default:     state_in = A_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_lv   = lv_ff;
      rd_idx  = k_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_lv   = lv_ff;
      wr_idx  = n[IDX_W-1:0];
      wr_data = {x_ff, y_ff};
      case (state_ff)
         A_INIT: begin
            wr_en   = !init_done;
            wr_lv   = '0;
            wr_idx  = counts_ff[0][IDX_W-1:0];
            wr_data = {ix_ff, iy_ff};
         end
         A_PUSH:    wr_en = (n < FULL);
         A_SCAN_RD: rd_en = 1'b1;
         A_DEL_RD: begin
            rd_en  = 1'b1;
            rd_idx = j_ff[IDX_W-1:0];
         end
         A_DEL_WR: begin
            wr_en   = 1'b1;
            wr_idx  = IDX_W'(j_ff - CNT_W'(3));
            wr_data = rd_ff;
         end
         A_INS_RD: begin
            rd_en  = 1'b1;
            rd_idx = IDX_W'(j_ff - CNT_W'(1));
         end
         A_INS_WR: begin
            wr_en   = 1'b1;
            wr_idx  = j_ff[IDX_W-1:0];
            wr_data = rd_ff;
         end
         A_INS_PUT: begin
            wr_en  = 1'b1;
            wr_idx = ins_ff[IDX_W-1:0];
         end
         A_SPLIT_RD, A_POP_RD: begin
            rd_en  = 1'b1;
            rd_idx = IDX_W'(n - CNT_W'(1));
         end
         A_SPLIT_PUSH: begin
            wr_en   = (m < FULL);
            wr_lv   = lv_up;
            wr_idx  = m[IDX_W-1:0];
            wr_data = {cx, cy};
         end
         default: rd_en = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      counts_in = counts_ff;
      lv_in  = lv_ff;
      alv_in = alv_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      ix_in  = ix_ff;
      iy_in  = iy_ff;
      rx_in  = rx_ff;
      ry_in  = ry_ff;
      k_in   = k_ff;
      eq_in  = eq_ff;
      ins_in = ins_ff;
      j_in   = j_ff;
      q_in   = q_ff;
      ok_in  = ok_ff;
      case (state_ff)
         A_INIT: begin
            if (!init_done) begin
               counts_in[0] = counts_ff[0] + CNT_W'(1);
               if (ix_ff == X_LAST) begin
                  ix_in = '0;
                  iy_in = iy_ff + BLK;
               end else begin
                  ix_in = ix_ff + BLK;
               end
            end
         end
         A_IDLE: begin
            if (start) begin
               lv_in  = cmd.free_lvl[LV_W-1:0];
               x_in   = cmd.free_x;
               y_in   = cmd.free_y;
               alv_in = cmd.alloc_lvl[LV_W-1:0];
            end
         end
         A_FREE_CHK: begin
            k_in   = '0;
            eq_in  = '0;
            ins_in = n;
         end
         A_PUSH: begin
            if (n < FULL) counts_in[lv_ff] = n + CNT_W'(1);
         end
         A_SCAN_USE: begin
            if (key_gt) begin
               ins_in = k_ff;
            end else if (key_eq) begin
               eq_in = eq_ff + CNT_W'(1);
            end
            k_in = k_ff + CNT_W'(1);
         end
         A_SCAN_END: begin
            j_in = merge ? ins_ff : n;
         end
         A_DEL_WR:  j_in = j_ff + CNT_W'(1);
         A_MERGE: begin
            // the three buddies and this block become their parent
            counts_in[lv_ff] = n - CNT_W'(3);
            x_in  = x_ff & mask;
            y_in  = y_ff & mask;
            lv_in = lv_ff - LV_W'(1);
         end
         A_INS_WR:  j_in = j_ff - CNT_W'(1);
         A_INS_PUT: counts_in[lv_ff] = n + CNT_W'(1);
         A_ALLOC_CHK: begin
            lv_in = src_lv;
            ok_in = 1'b0;
         end
         A_SPLIT_RD: counts_in[lv_ff] = n - CNT_W'(1);
         A_SPLIT_USE: begin
            x_in = rd_ff[2*CRD_W-1:CRD_W];
            y_in = rd_ff[CRD_W-1:0];
            q_in = 2'd0;
         end
         A_SPLIT_PUSH: begin
            if (m < FULL) counts_in[lv_up] = m + CNT_W'(1);
            q_in = q_ff + 2'd1;
            if (q_ff == 2'd3) lv_in = lv_up;
         end
         A_POP_RD: counts_in[lv_ff] = n - CNT_W'(1);
         A_POP_USE: begin
            rx_in = rd_ff[2*CRD_W-1:CRD_W];
            ry_in = rd_ff[CRD_W-1:0];
            ok_in = 1'b1;
         end
         default: ok_in = ok_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= A_INIT;
         counts_ff <= '{default: '0};
         ix_ff     <= '0;
         iy_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         counts_ff <= counts_in;
         ix_ff     <= ix_in;
         iy_ff     <= iy_in;
      end
   end

   always_ff @(posedge clock) begin
      lv_ff  <= lv_in;
      alv_ff <= alv_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      k_ff   <= k_in;
      eq_ff  <= eq_in;
      ins_ff <= ins_in;
      j_ff   <= j_in;
      q_ff   <= q_in;
      ok_ff  <= ok_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= free_mem[rd_lv][rd_idx];
      if (wr_en) free_mem[wr_lv][wr_idx] <= wr_data;
   end

   assign rsp.ready = (state_ff == A_IDLE);
   assign rsp.done  = (state_ff == A_DONE);
   assign rsp.ok    = ok_ff;
   assign rsp.x     = rx_ff;
   assign rsp.y     = ry_ff;

endmodule

// ----- rtl/aqa_back.sv -----
// ----------------------------------------------------------------------------
// aqa_back
// Carries out queued items: light table lookup, block allocation, table
// update and the registered result.
// ----------------------------------------------------------------------------
module aqa_back #(
   parameter int ATLAS_WIDTH    = 8192,
   parameter int ATLAS_HEIGHT   = 8192,
   parameter int MAX_BLOCK_LOG2 = 11,
   parameter int NUM_LEVELS     = 5,
   parameter int MAX_LIGHTS     = 64,
   parameter int LIST_DEPTH     = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cache_en,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  aqa_pkg::req_type              q_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [12:0]                   rsp_block_x,
   output logic [12:0]                   rsp_block_y,
   output logic [11:0]                   rsp_block_size,
   output logic                          rsp_static_hit,
   output logic [1:0]                    rsp_status
);
   import aqa_pkg::*;

   localparam int SW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

   back_state_type  state_ff, state_in;
   req_type         item_ff, item_in;
   logic            hit_ff, hit_in;
   status_type      status_ff, status_in;
   logic [CRD_W-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [12:0]     rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [11:0]     rsp_size_ff, rsp_size_in;
   logic            rsp_hit_ff, rsp_hit_in;
   status_type      rsp_status_ff, rsp_status_in;

   look_rsp_type    look_rsp;
   logic [SW-1:0]   hit_slot, free_slot, wr_slot;
   entry_type       hit_entry, wr_entry;
   logic            look_start, wr_en, clr_en, alloc_start, load, same;
   alloc_cmd_type   alloc_cmd;
   alloc_rsp_type   alloc_rsp;
   logic [15:0]     size_oh;

   aqa_lights #(.MAX_LIGHTS(MAX_LIGHTS)) u_lights (
      .clock     (clock),
      .reset     (reset),
      .look_start(look_start),
      .look_id   (item_ff.id),
      .look_rsp  (look_rsp),
      .hit_slot  (hit_slot),
      .free_slot (free_slot),
      .hit_entry (hit_entry),
      .wr_en     (wr_en),
      .wr_slot   (wr_slot),
      .wr_entry  (wr_entry),
      .clr_en    (clr_en),
      .clr_slot  (hit_slot)
   );

   aqa_alloc #(
      .ATLAS_WIDTH   (ATLAS_WIDTH),
      .ATLAS_HEIGHT  (ATLAS_HEIGHT),
      .MAX_BLOCK_LOG2(MAX_BLOCK_LOG2),
      .NUM_LEVELS    (NUM_LEVELS),
      .LIST_DEPTH    (LIST_DEPTH)
   ) u_alloc (
      .clock(clock),
      .reset(reset),
      .start(alloc_start),
      .cmd  (alloc_cmd),
      .rsp  (alloc_rsp)
   );

   assign same = look_rsp.found && (hit_entry.lvl == item_ff.lvl);
   assign load = (state_ff == B_OUT) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (q_valid && alloc_rsp.ready) state_in = B_LOOK;
         B_LOOK: state_in = B_WAIT;
         B_WAIT: if (look_rsp.done) state_in = B_DECIDE;
         B_DECIDE: begin
            if (same || (!look_rsp.found && !look_rsp.free_ok)) begin
               state_in = B_OUT;
            end else begin
               state_in = B_AWAIT;
            end
         end
         B_AWAIT: if (alloc_rsp.done) state_in = B_OUT;
         B_OUT:   if (load) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop       = (state_ff == B_IDLE) && q_valid && alloc_rsp.ready;
      look_start  = (state_ff == B_LOOK);
      alloc_start = (state_ff == B_DECIDE) && !same &&
                    (look_rsp.found || look_rsp.free_ok);
      alloc_cmd.do_free   = look_rsp.found;
      alloc_cmd.free_lvl  = hit_entry.lvl;
      alloc_cmd.free_x    = hit_entry.x;
      alloc_cmd.free_y    = hit_entry.y;
      alloc_cmd.alloc_lvl = item_ff.lvl;
      wr_en    = 1'b0;
      clr_en   = 1'b0;
      wr_slot  = look_rsp.found ? hit_slot : free_slot;
      wr_entry.id   = item_ff.id;
      wr_entry.hash = item_ff.hash;
      wr_entry.x    = alloc_rsp.x;
      wr_entry.y    = alloc_rsp.y;
      wr_entry.lvl  = item_ff.lvl;
      case (state_ff)
         B_DECIDE: begin
            if (same) begin
               wr_en      = 1'b1;
               wr_entry.x = hit_entry.x;
               wr_entry.y = hit_entry.y;
            end
         end
         B_AWAIT: begin
            if (alloc_rsp.done) begin
               wr_en  = alloc_rsp.ok;
               // no block after freeing the old one: drop the light
               clr_en = !alloc_rsp.ok && look_rsp.found;
            end
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_comb begin
      item_in   = item_ff;
      hit_in    = hit_ff;
      status_in = status_ff;
      res_x_in  = res_x_ff;
      res_y_in  = res_y_ff;
      case (state_ff)
         B_IDLE: item_in = q_item;
         B_DECIDE: begin
            hit_in    = same && (hit_entry.hash == item_ff.hash);
            res_x_in  = hit_entry.x;
            res_y_in  = hit_entry.y;
            status_in = (!look_rsp.found && !look_rsp.free_ok) ? STATUS_TABLE_FULL
                                                               : STATUS_OK;
         end
         B_AWAIT: begin
            if (alloc_rsp.done) begin
               res_x_in  = alloc_rsp.x;
               res_y_in  = alloc_rsp.y;
               status_in = alloc_rsp.ok ? STATUS_OK : STATUS_NO_BLOCK;
            end
         end
         default: hit_in = hit_ff;
      endcase
   end

   assign size_oh = 16'd1 << item_ff.lg;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         if (status_ff == STATUS_OK) begin
            rsp_x_in    = res_x_ff[12:0];
            rsp_y_in    = res_y_ff[12:0];
            rsp_size_in = size_oh[11:0];
            rsp_hit_in  = hit_ff && cache_en;
         end else begin
            rsp_x_in    = '0;
            rsp_y_in    = '0;
            rsp_size_in = '0;
            rsp_hit_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      hit_ff        <= hit_in;
      status_ff     <= status_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_block_x    = rsp_x_ff;
   assign rsp_block_y    = rsp_y_ff;
   assign rsp_block_size = rsp_size_ff;
   assign rsp_static_hit = rsp_hit_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives light requests into the atlas block allocator, predicts each block
// assignment with a behavioral quadtree buddy allocator and compares results.
// ----------------------------------------------------------------------------
module testbench;
   import aqa_pkg::*;

   localparam int ATLAS_DIM  = 8192;
   localparam int MAX_LG     = 11;
   localparam int MIN_LG     = 7;
   localparam int NUM_LVL    = MAX_LG - MIN_LG + 1;
   localparam int NUM_LIGHTS = 64;
   localparam int LIST_MAX   = 4096;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [12:0] x;
      logic [12:0] y;
      logic [11:0] size;
      logic        hit;
      status_type  status;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ID_W-1:0] req_light_id = '0;
   logic [HASH_W-1:0] req_movement_hash = '0;
   logic [SIZE_W-1:0] req_size_log2 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [12:0] rsp_block_x;
   logic [12:0] rsp_block_y;
   logic [11:0] rsp_block_size;
   logic rsp_static_hit;
   logic [1:0] rsp_status;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   atlas_quadtree_allocator i_dut (.*);

   initial forever #2 clock = ~clock;

   // allocator shadow state
   int unsigned fx[NUM_LVL][$];
   int unsigned fy[NUM_LVL][$];
   bit          lt_valid[NUM_LIGHTS];
   logic [63:0] lt_id[NUM_LIGHTS];
   logic [63:0] lt_hash[NUM_LIGHTS];
   int unsigned lt_x[NUM_LIGHTS];
   int unsigned lt_y[NUM_LIGHTS];
   int          lt_lvl[NUM_LIGHTS];
   bit          cache_en;

   grant_type   pending_grants[$];
   int          fail_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          long_hold = 1'b0;
   longint      cycle_count = 0;

   function automatic void reset_shadow();
      for (int l = 0; l < NUM_LVL; l++) begin
         fx[l].delete();
         fy[l].delete();
      end
      for (int y = 0; y < ATLAS_DIM >> MAX_LG; y++)
         for (int x = 0; x < ATLAS_DIM >> MAX_LG; x++) begin
            fx[0].insert(fx[0].size(), x << MAX_LG);
            fy[0].insert(fy[0].size(), y << MAX_LG);
         end
      foreach (lt_valid[i]) lt_valid[i] = 1'b0;
      cache_en = 1'b1;
   endfunction

   function automatic void push_free(int l, int unsigned x, int unsigned y);
      if (fx[l].size() >= LIST_MAX) return;
      fx[l].insert(fx[l].size(), x);
      fy[l].insert(fy[l].size(), y);
   endfunction

   function automatic bit take_block(int lvl, output int unsigned bx, output int unsigned by);
      int src;
      int unsigned h, px, py;
      src = lvl;
      bx = 0;
      by = 0;
      while (src >= 0 && fx[src].size() == 0) src--;
      if (src < 0) return 1'b0;
      for (int i = src; i < lvl; i++) begin
         h = 1 << (MAX_LG - i - 1);
         px = fx[i][$];
         py = fy[i][$];
         fx[i].delete(fx[i].size() - 1);
         fy[i].delete(fy[i].size() - 1);
         push_free(i + 1, px, py);
         push_free(i + 1, px + h, py);
         push_free(i + 1, px, py + h);
         push_free(i + 1, px + h, py + h);
      end
      if (fx[lvl].size() == 0) return 1'b0;
      bx = fx[lvl][$];
      by = fy[lvl][$];
      fx[lvl].delete(fx[lvl].size() - 1);
      fy[lvl].delete(fy[lvl].size() - 1);
      return 1'b1;
   endfunction

   function automatic void return_block(int lvl, int unsigned x, int unsigned y);
      int unsigned n, sh, pw, pidx, pi, cnt, ins;
      forever begin
         if (lvl == 0 || fx[lvl].size() == 0) begin
            push_free(lvl, x, y);
            return;
         end
         n = fx[lvl].size();
         sh = MAX_LG - lvl + 1;
         pw = ATLAS_DIM >> sh;
         pidx = (y >> sh) * pw + (x >> sh);
         cnt = 0;
         ins = n;
         for (int k = 0; k < n; k++) begin
            pi = (fy[lvl][k] >> sh) * pw + (fx[lvl][k] >> sh);
            if (pi == pidx) cnt++;
            else if (pi > pidx) begin
               ins = k;
               break;
            end
         end
         if (cnt == 3 && ins >= 3) begin
            // merge the three buddies with this block into the parent
            for (int r = 0; r < 3; r++) begin
               fx[lvl].delete(ins - 3);
               fy[lvl].delete(ins - 3);
            end
            x = (x >> sh) << sh;
            y = (y >> sh) << sh;
            lvl--;
         end else begin
            if (n < LIST_MAX) begin
               fx[lvl].insert(ins, x);
               fy[lvl].insert(ins, y);
            end
            return;
         end
      end
   endfunction

   function automatic grant_type predict_grant(logic [63:0] id, logic [63:0] hash,
                                               logic [3:0] lg_in);
      grant_type g;
      int lg, lvl, slot;
      int unsigned bx, by;
      bit hit;
      g = '{default: '0};
      g.status = STATUS_OK;
      hit = 1'b0;
      lg = lg_in;
      if (lg < MIN_LG) lg = MIN_LG;
      if (lg > MAX_LG) lg = MAX_LG;
      lvl = MAX_LG - lg;
      slot = -1;
      for (int i = 0; i < NUM_LIGHTS; i++)
         if (lt_valid[i] && lt_id[i] == id) begin
            slot = i;
            break;
         end
      if (slot < 0) begin
         for (int i = 0; i < NUM_LIGHTS; i++)
            if (!lt_valid[i]) begin
               slot = i;
               break;
            end
         if (slot < 0) g.status = STATUS_TABLE_FULL;
         else if (!take_block(lvl, bx, by)) g.status = STATUS_NO_BLOCK;
         else begin
            lt_valid[slot] = 1'b1;
            lt_id[slot] = id;
            lt_hash[slot] = hash;
            lt_x[slot] = bx;
            lt_y[slot] = by;
            lt_lvl[slot] = lvl;
         end
      end else if (lt_lvl[slot] != lvl) begin
         return_block(lt_lvl[slot], lt_x[slot], lt_y[slot]);
         if (!take_block(lvl, bx, by)) begin
            lt_valid[slot] = 1'b0;
            g.status = STATUS_NO_BLOCK;
         end else begin
            lt_x[slot] = bx;
            lt_y[slot] = by;
            lt_lvl[slot] = lvl;
            lt_hash[slot] = hash;
         end
      end else begin
         hit = (lt_hash[slot] == hash);
         lt_hash[slot] = hash;
      end
      if (g.status == STATUS_OK) begin
         g.x = lt_x[slot][12:0];
         g.y = lt_y[slot][12:0];
         g.size = 12'((1 << lg) & 'hFFF);
         g.hit = hit & cache_en;
      end
      return g;
   endfunction

   // valid stays high after an accepted item until the next item or an idle cycle
   task automatic send_request(logic [63:0] id, logic [63:0] hash, logic [3:0] lg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_light_id <= id;
      req_movement_hash <= hash;
      req_size_log2 <= lg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_grants.insert(pending_grants.size(), predict_grant(id, hash, lg));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_cache_enable(bit value);
      wait_drained();
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= 3'(4 * REG_STATIC_CACHE);
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cache_en = value;
   endtask

   // known sizes, clamping, hash hits, size changes and running out of blocks
   task automatic test_directed();
      logic [63:0] top = '1;
      send_request(64'd0, 64'd0, 4'd11);
      send_request(64'd0, 64'd0, 4'd11);
      send_request(64'd0, 64'd1, 4'd11);
      send_request(top, top, 4'd7);
      send_request(top, top, 4'd7);
      send_request(64'd5, 64'd9, 4'd0);
      send_request(64'd5, 64'd9, 4'd15);
      send_request(64'd6, 64'h5555_aaaa_5555_aaaa, 4'd9);
      send_request(64'd6, 64'haaaa_5555_aaaa_5555, 4'd8);
      send_request(64'd6, 64'haaaa_5555_aaaa_5555, 4'd10);
      send_request(top, 64'd3, 4'd11);
      // exhaust the 16 top-level blocks to force a no-block status
      for (int i = 0; i < 16; i++) send_request(64'd100 + i, 64'd0, 4'd11);
      send_request(top, 64'd3, 4'd7);
   endtask

   task automatic test_table_full();
      wait_drained();
      for (int i = 0; i < NUM_LIGHTS + 2; i++)
         send_request(64'h1000 + i, 64'(i), 4'd7);
   endtask

   task automatic test_random(int count);
      logic [63:0] id, hash;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) id = {$urandom, $urandom};
         else id = 64'($urandom_range(40)) | (64'($urandom_range(1)) << 63);
         hash = ($urandom_range(2) == 0) ? {$urandom, $urandom} : 64'($urandom_range(3));
         send_request(id, hash, 4'($urandom_range(15)));
      end
   endtask

   task automatic test_backpressure();
      long_hold = 1'b1;
      for (int i = 0; i < 6; i++) send_request(64'($urandom_range(30)), 64'd1, 4'd9);
      wait_drained();
   endtask

   always @(negedge clock) begin
      if (long_hold) begin
         rsp_stall <= 1'b1;
         repeat (400) @(negedge clock);
         long_hold <= 1'b0;
         rsp_stall <= 1'b0;
      end else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      grant_type g;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            $display("%0t unexpected result expected none actual x=%0d y=%0d status=%0d",
                     $time, rsp_block_x, rsp_block_y, rsp_status);
            fail_count++;
         end else begin
            g = pending_grants.pop_front();
            if (g.x !== rsp_block_x || g.y !== rsp_block_y || g.size !== rsp_block_size ||
                g.hit !== rsp_static_hit || g.status !== rsp_status) begin
               $display("%0t mismatch expected x=%0d y=%0d size=%0d hit=%0d status=%0d",
                        $time, g.x, g.y, g.size, g.hit, g.status);
               $display("%0t          actual   x=%0d y=%0d size=%0d hit=%0d status=%0d",
                        $time, rsp_block_x, rsp_block_y, rsp_block_size, rsp_static_hit,
                        rsp_status);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset_shadow();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      write_cache_enable(1'b0);
      send_request(64'd5, 64'd9, 4'd15);
      send_request(64'd5, 64'd9, 4'd15);
      write_cache_enable(1'b1);
      test_table_full();
      send_idle_pct = 8;
      recv_idle_pct = 53;
      test_random(280);
      test_backpressure();
      write_cache_enable(1'b0);
      send_idle_pct = 53;
      recv_idle_pct = 8;
      test_random(280);
      write_cache_enable(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(200);
      wait_drained();
      if (fail_count == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/aqa_pkg.sv
rtl/aqa_front.sv
rtl/aqa_lights.sv
rtl/aqa_alloc.sv
rtl/aqa_back.sv
rtl/atlas_quadtree_allocator.sv
tb/testbench.sv
